// ===== hw/rtl/rsas_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the rotated sorted array search block
package rsas_pkg;

  localparam int DATA_W = 32;

  // request codes on the input channel
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // search sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_RD_LO,
    ST_RD_HI,
    ST_DECIDE,
    ST_DONE
  } state_t;

endpackage

// ===== hw/rtl/rsas_req_if.sv =====
`timescale 1ns / 1ps
// request channel: element loads and key searches
interface rsas_req_if
  import rsas_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic signed [DATA_W-1:0] value;
  logic                     first_element;

  modport source (output valid, req_type, value, first_element, input ready);
  modport sink   (input valid, req_type, value, first_element, output ready);
endinterface

// ===== hw/rtl/rsas_rsp_if.sv =====
`timescale 1ns / 1ps
// response channel: one beat per search
interface rsas_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic load_overflowed;

  modport source (output valid, found, load_overflowed, input ready);
  modport sink   (input valid, found, load_overflowed, output ready);
endinterface

// ===== hw/rtl/rsas_ram.sv =====
`timescale 1ns / 1ps
// generic simple dual port ram, one write port, one registered read port
module rsas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/rotated_sorted_array_search_top.sv =====
`timescale 1ns / 1ps
// top level: element store and binary search sequencer for rotated sorted arrays
//
// usage
//   req channel carries loads (req_type = 0) and searches (req_type = 1)
//   a load with first_element set starts a new set at index 0, otherwise the
//   element is appended; loads past STORE_DEPTH are dropped and flagged
//   a load returns nothing; loads stream back to back while no search runs
//   a search returns one beat on rsp: found and load_overflowed
//   a search walks probes until the range empties or a[mid] matches the key;
//   a hit ends the search at the mid compare; probes up to ceil(log2(n + 1))
//   for n loaded elements
//   every probe that misses a[mid] makes three reads (mid, lo, hi) through the
//   single read port of the element ram, one per cycle, plus a decide step;
//   that port bounds the search speed, and req.ready is low while a search runs
//   the result sits in an output register, so a new request is taken while
//   a finished result still waits; if rsp stalls with a full output register
//   the sequencer holds its result and req stays blocked until it drains
//   reset clears the element count, the overflow flag, the sequencer and
//   the output valid flag; ram contents are not cleared
module rotated_sorted_array_search_top
  import rsas_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst,
  rsas_req_if.sink    req,
  rsas_rsp_if.source  rsp
);

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW = $clog2(STORE_DEPTH + 1);  // count holds the depth itself
  localparam int PW = CW + 1;                   // signed index, hi may reach -1

  state_t state, state_next;

  // set bookkeeping
  logic [CW-1:0] count;
  logic          ovf;

  // search registers
  logic signed [DATA_W-1:0] key;
  logic signed [PW-1:0]     lo, hi, mid;
  logic signed [DATA_W-1:0] a_mid;
  logic                     found_r;
  logic                     key_lt_mid, mid_lt_key;  // from the mid read
  logic                     lo_le_mid, lo_le_key;    // from the lo read

  // output register
  logic out_valid, out_found, out_ovf;

  // ram ports
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [DATA_W-1:0]    ram_rdata;
  logic signed [DATA_W-1:0] rd_s;

  logic                 req_fire, load_fire, search_fire;
  logic [CW-1:0]        base;
  logic                 room;
  logic signed [PW-1:0] mid_calc;
  logic                 rd_eq, out_free, key_le_hi, go_left;

  assign req.ready   = (state == ST_IDLE);
  assign req_fire    = req.valid && req.ready;
  assign load_fire   = req_fire && (req.req_type == REQ_LOAD);
  assign search_fire = req_fire && (req.req_type == REQ_SEARCH);

  // first mark restarts the set before this element is placed
  assign base      = req.first_element ? '0 : count;
  assign room      = (base < CW'(STORE_DEPTH));
  assign ram_we    = load_fire && room;
  assign ram_waddr = base[AW-1:0];

  assign mid_calc = lo + ((hi - lo) >>> 1);
  assign rd_s     = signed'(ram_rdata);
  assign rd_eq    = (rd_s == key);
  assign out_free = !out_valid || rsp.ready;

  // last compare of a probe: ram data is a[hi] in the decide cycle
  assign key_le_hi = (key <= rd_s);
  always_comb begin
    if (lo_le_mid) begin
      go_left = lo_le_key && key_lt_mid;
    end else begin
      go_left = !(mid_lt_key && key_le_hi);
    end
  end

  rsas_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer: next state and read address
  always_comb begin
    state_next = state;
    ram_raddr  = mid_calc[AW-1:0];
    case (state)
      ST_IDLE: begin
        if (search_fire) begin
          state_next = ST_PROBE;
        end
      end
      ST_PROBE: begin
        // empty range ends the search, else read a[mid]
        state_next = (lo > hi) ? ST_DONE : ST_RD_LO;
      end
      ST_RD_LO: begin
        ram_raddr  = lo[AW-1:0];
        state_next = rd_eq ? ST_DONE : ST_RD_HI;
      end
      ST_RD_HI: begin
        ram_raddr  = hi[AW-1:0];
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        state_next = ST_PROBE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // element count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else if (load_fire) begin
      if (room) begin
        count <= base + CW'(1);
        if (req.first_element) begin
          ovf <= 1'b0;
        end
      end else begin
        count <= base;
        ovf   <= 1'b1;
      end
    end
  end

  // search datapath, one compare group per read
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (search_fire) begin
          key     <= req.value;
          lo      <= '0;
          hi      <= signed'({1'b0, count}) - PW'(1);
          found_r <= 1'b0;
        end
      end
      ST_PROBE: begin
        mid <= mid_calc;
      end
      ST_RD_LO: begin
        // ram data is a[mid]
        a_mid      <= rd_s;
        key_lt_mid <= (key < rd_s);
        mid_lt_key <= (rd_s < key);
        if (rd_eq) begin
          found_r <= 1'b1;
        end
      end
      ST_RD_HI: begin
        // ram data is a[lo]
        lo_le_mid <= (rd_s <= a_mid);
        lo_le_key <= (rd_s <= key);
      end
      ST_DECIDE: begin
        if (go_left) begin
          hi <= mid - PW'(1);
        end else begin
          lo <= mid + PW'(1);
        end
      end
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_found <= found_r;
      out_ovf   <= ovf;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.found           = out_found;
  assign rsp.load_overflowed = out_ovf;

  // count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STORE_DEPTH))
    else $error("element count beyond store depth");

  // every probe reads an index inside the written part of the set
  a_mid_in_set: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_LO |-> (mid >= lo) && (mid <= hi) && (mid >= 0)
      && (mid < signed'({1'b0, count})))
    else $error("probe outside loaded elements");

  // a finished search lands in the output register next cycle
  a_result_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free |=> out_valid && state == ST_IDLE)
    else $error("search result not delivered");

  // the store is not written while a search runs
  a_no_write_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !ram_we)
    else $error("store written during search");

endmodule

// ===== tb/tb_rotated_sorted_array_search_top.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the rotated sorted array search top level
module tb_rotated_sorted_array_search_top;
  import rsas_pkg::*;

  localparam int STORE_DEPTH = 1024;
  localparam int WORD_MAX = 32'sh7FFF_FFFF;
  localparam int WORD_MIN = 32'sh8000_0000;
  // long response hold-off, in cycles, to back the block up into req
  localparam int HOLD_CYCLES = 200;
  // random part stops issuing once this many beats went in
  localparam int ITEM_TARGET = 520;

  // one row of the directed table; typed rows carry their answer
  typedef struct packed {
    logic                     rtype;
    logic signed [DATA_W-1:0] val;
    logic                     first;
    logic                     typed;
    logic                     found;
    logic                     ovf;
  } stim_row_t;

  // one expected response beat
  typedef struct packed {
    logic found;
    logic ovf;
  } answer_t;

  localparam int N_DIR = 25;
  localparam stim_row_t DIR_ROWS [N_DIR] = '{
    // empty set straight after reset: nothing can be found
    '{REQ_SEARCH, 32'sd0,         1'b0, 1'b1, 1'b0, 1'b0},
    // load with no first mark appends, also right after reset
    '{REQ_LOAD,   WORD_MAX,       1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_SEARCH, WORD_MAX,       1'b0, 1'b1, 1'b1, 1'b0},
    '{REQ_SEARCH, WORD_MIN,       1'b0, 1'b1, 1'b0, 1'b0},
    // rotated set spanning both extremes: 5 6 max min -1 3
    '{REQ_LOAD,   32'sd5,         1'b1, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   32'sd6,         1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   WORD_MAX,       1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   WORD_MIN,       1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   -32'sd1,        1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   32'sd3,         1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_SEARCH, WORD_MIN,       1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_SEARCH, WORD_MAX,       1'b0, 1'b0, 1'b0, 1'b0},
    // first mark on a search is ignored
    '{REQ_SEARCH, 32'sd4,         1'b1, 1'b0, 1'b0, 1'b0},
    '{REQ_SEARCH, 32'sd3,         1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_SEARCH, 32'sd5,         1'b0, 1'b0, 1'b0, 1'b0},
    // duplicates: the probe may step past a present key
    '{REQ_LOAD,   32'sd2,         1'b1, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   32'sd2,         1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   32'sd2,         1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   32'sd1,         1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_LOAD,   32'sd2,         1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_SEARCH, 32'sd1,         1'b0, 1'b0, 1'b0, 1'b0},
    '{REQ_SEARCH, 32'sd2,         1'b0, 1'b0, 1'b0, 1'b0},
    // single element set
    '{REQ_LOAD,   -32'sd7,        1'b1, 1'b0, 1'b0, 1'b0},
    '{REQ_SEARCH, -32'sd7,        1'b0, 1'b1, 1'b1, 1'b0},
    '{REQ_SEARCH, 32'sd0,         1'b0, 1'b1, 1'b0, 1'b0}
  };

  logic clk;
  logic rst = 1'b1;

  rsas_req_if req ();
  rsas_rsp_if rsp ();

  rotated_sorted_array_search_top #(
    .STORE_DEPTH(STORE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // shadow of the element store and the set bookkeeping
  int      set_words [STORE_DEPTH];
  int      set_len = 0;
  bit      set_dropped = 1'b0;

  // answers still owed by the block, oldest first
  answer_t pending_answers [$];

  // contents of the current set, sorted unless a stray append follows, used to pick present keys
  int      set_keys [$];

  // pacing controls shared between stimulus and the response side
  bit      src_calm = 1'b0;
  bit      snk_calm = 1'b0;
  bit      hold_rsp_req = 1'b0;

  int      items_sent = 0;
  int      n_loads = 0;
  int      n_searches = 0;
  int      n_hits = 0;
  int      n_ovf = 0;
  int      n_checked = 0;
  int      mismatches = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block wedges
  initial begin
    #10_000_000;
    $display("rotated_sorted_array_search_top regression: fail");
    $finish;
  end

  // binary search over a rotated ascending set, same probe order as the block
  function automatic bit key_in_rotated_set(int key);
    int lo, hi, mid;
    int w_lo, w_mid, w_hi;
    lo = 0;
    hi = set_len - 1;
    while (lo <= hi) begin
      mid   = lo + (hi - lo) / 2;
      w_lo  = set_words[lo];
      w_mid = set_words[mid];
      w_hi  = set_words[hi];
      if (w_mid == key) return 1'b1;
      if (w_lo <= w_mid) begin
        // left half sorted
        if (w_lo <= key && key < w_mid) hi = mid - 1;
        else lo = mid + 1;
      end else begin
        // right half sorted
        if (w_mid < key && key <= w_hi) lo = mid + 1;
        else hi = mid - 1;
      end
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap(bit calm);
    if (calm) return 0;
    return $urandom_range(0, 11);
  endfunction

  // mode 0: full range, mode 1: narrow range with many repeats, else extremes mix
  function automatic int pick_word(int mode);
    int sel;
    sel = $urandom_range(0, 3);
    if (mode == 0) return $urandom();
    if (mode == 1) return int'($urandom_range(0, 24)) - 12;
    case (sel)
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return $urandom();
      default: return int'($urandom_range(0, 24)) - 12;
    endcase
  endfunction

  // keys lean toward set members and their neighbors so hits are common
  function automatic int pick_key();
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    if (set_keys.size() > 0 && sel < 7) begin
      k = set_keys[$urandom_range(0, set_keys.size() - 1)];
      if (sel == 5) return k + 1;
      if (sel == 6) return k - 1;
      return k;
    end
    if (sel == 7) return ($urandom_range(0, 1) != 0) ? WORD_MAX : WORD_MIN;
    if (sel == 8) return int'($urandom_range(0, 24)) - 12;
    return $urandom();
  endfunction

  // update the shadow on an accepted beat and queue the answer for a search
  task automatic record_accept(input logic rtype, input int val, input logic first,
                               input logic typed, input logic t_found, input logic t_ovf);
    answer_t ans;
    if (rtype == REQ_LOAD) begin
      n_loads++;
      if (first) begin
        set_len     = 0;
        set_dropped = 1'b0;
      end
      if (set_len < STORE_DEPTH) begin
        set_words[set_len] = val;
        set_len++;
      end else begin
        set_dropped = 1'b1;
      end
    end else begin
      n_searches++;
      ans.found = typed ? t_found : key_in_rotated_set(val);
      ans.ovf   = typed ? t_ovf : set_dropped;
      if (ans.found) n_hits++;
      if (ans.ovf) n_ovf++;
      pending_answers.push_back(ans);
    end
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(input logic rtype, input int val, input logic first,
                           input logic typed = 1'b0, input logic t_found = 1'b0,
                           input logic t_ovf = 1'b0);
    int gap;
    gap = pick_gap(src_calm);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req.valid         <= 1'b1;
    req.req_type      <= rtype;
    req.value         <= val;
    req.first_element <= first;
    do @(posedge clk); while (req.ready !== 1'b1);
    record_accept(rtype, val, first, typed, t_found, t_ovf);
    items_sent++;
    @(negedge clk);
  endtask

  // sender goes quiet until every owed answer is back
  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // sorted random words, rotated by a random amount, first one marked
  task automatic load_rotated_set(input int n, input int mode);
    int words [$];
    int rot;
    for (int i = 0; i < n; i++) words.push_back(pick_word(mode));
    words.sort();
    rot = $urandom_range(0, n - 1);
    set_keys.delete();
    for (int i = 0; i < n; i++) begin
      send_item(REQ_LOAD, words[(i + rot) % n], i == 0);
      set_keys.push_back(words[i]);
    end
  endtask

  task automatic search_burst(input int count);
    for (int i = 0; i < count; i++)
      send_item(REQ_SEARCH, pick_key(), $urandom_range(0, 7) == 0);
  endtask

  // response side: random ready pacing plus the long hold-off on request
  initial begin
    int idle;
    rsp.ready = 1'b0;
    wait (rst == 1'b0);
    @(negedge clk);
    forever begin
      if (hold_rsp_req) begin
        hold_rsp_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      idle = pick_gap(snk_calm);
      if (idle > 0) begin
        rsp.ready <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      // one beat per draw; a hold-off request cuts the wait short
      do @(posedge clk); while (rsp.valid !== 1'b1 && !hold_rsp_req);
      @(negedge clk);
    end
  end

  // response checker: every beat against the oldest owed answer
  initial begin
    answer_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (pending_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("error: response beat with no search pending: found=%0b ovf=%0b",
                     rsp.found, rsp.load_overflowed);
        end else begin
          want = pending_answers.pop_front();
          if (rsp.found !== want.found || rsp.load_overflowed !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10)
              $display("error: search answer %0d: found exp %0b got %0b, ovf exp %0b got %0b",
                       n_checked, want.found, rsp.found, want.ovf, rsp.load_overflowed);
          end
        end
        n_checked++;
      end
    end
  end

  // stimulus
  initial begin
    int n;
    int mode;
    req.valid         = 1'b0;
    req.req_type      = REQ_LOAD;
    req.value         = '0;
    req.first_element = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: extremes, empty set, append after reset, duplicates
    for (int r = 0; r < N_DIR; r++) begin
      send_item(DIR_ROWS[r].rtype, DIR_ROWS[r].val, DIR_ROWS[r].first,
                DIR_ROWS[r].typed, DIR_ROWS[r].found, DIR_ROWS[r].ovf);
    end
    set_keys.delete();
    set_keys.push_back(-7);

    // random sets of modest size, each followed by a few searches
    while (items_sent < ITEM_TARGET) begin
      src_calm = ($urandom_range(0, 5) == 0);
      snk_calm = ($urandom_range(0, 5) == 0);
      n    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      mode = $urandom_range(0, 2);
      load_rotated_set(n, mode);
      // occasional stray append that breaks the ordering
      if ($urandom_range(0, 7) == 0) begin
        n = pick_word(mode);
        send_item(REQ_LOAD, n, 1'b0);
        set_keys.push_back(n);
      end
      search_burst($urandom_range(1, 6));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    // back-pressure: response side holds off while searches keep coming
    src_calm     = 1'b1;
    snk_calm     = 1'b0;
    hold_rsp_req = 1'b1;
    search_burst(8);
    wait_drained();

    // full store, then loads past the end get dropped and flagged
    src_calm = 1'b0;
    load_rotated_set(STORE_DEPTH, 0);
    search_burst(6);
    repeat (3) send_item(REQ_LOAD, $urandom(), 1'b0);
    search_burst(6);

    // a new set clears the overflow flag
    load_rotated_set(5, 1);
    search_burst(4);

    wait_drained();
    repeat (60) @(posedge clk);

    $display("covered %0d loads and %0d searches: %0d keys found, %0d with overflow set",
             n_loads, n_searches, n_hits, n_ovf);
    $display("sets ranged from empty to a full store with dropped loads, under random stalls");
    if (mismatches == 0) begin
      $display("rotated_sorted_array_search_top regression: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("rotated_sorted_array_search_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rsas_pkg.sv
hw/rtl/rsas_req_if.sv
hw/rtl/rsas_rsp_if.sv
hw/rtl/rsas_ram.sv
hw/rtl/rotated_sorted_array_search_top.sv
tb/tb_rotated_sorted_array_search_top.sv
